// File: rtl/tbv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbv_pkg;

    localparam int NUM_BINS    = 8;
    localparam int BIN_W       = 3;
    localparam int SAMPLE_W    = 16;
    localparam int SPS_W       = 4;
    localparam int TOTAL_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [SPS_W-1:0] SPS_RESET = 4'd6;

    // register indexes on the configuration port
    localparam logic REG_SAMPLES_PER_SYMBOL = 1'b0;

    // open ranges, lower bin index wins where two would hit
    localparam logic [SAMPLE_W-1:0] BIN_LOW [NUM_BINS] = '{
        16'd3100, 16'd3400, 16'd3600, 16'd3800,
        16'd2600, 16'd3880, 16'd4650, 16'd4100
    };
    localparam logic [SAMPLE_W-1:0] BIN_HIGH [NUM_BINS] = '{
        16'd3400, 16'd3600, 16'd3800, 16'd3880,
        16'd3100, 16'd4100, 16'd6000, 16'd4650
    };

    // one classified sample travelling from front to back
    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
        logic             last;
    } tbv_item_t;

    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
    } tbv_class_t;

    function automatic tbv_class_t tbv_classify(input logic [SAMPLE_W-1:0] v);
        tbv_class_t c;
        c.hit = 1'b0;
        c.bin = '0;
        for (int b = NUM_BINS - 1; b >= 0; b--) begin
            if ((v > BIN_LOW[b]) && (v < BIN_HIGH[b])) begin
                c.hit = 1'b1;
                c.bin = BIN_W'(b);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tbv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbv_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tbv_pkg::SAMPLE_W-1:0] s_timing_sample,
    input  wire logic [tbv_pkg::SPS_W-1:0]    samples_per_symbol,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output tbv_pkg::tbv_item_t                push_item
);
    import tbv_pkg::*;

    logic [SPS_W-1:0] position_reg;
    logic [SPS_W-1:0] position_next;
    tbv_class_t       cls;
    logic             last;
    logic             accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // a zero length behaves like one: every sample closes the symbol
    assign last = ({1'b0, position_reg} + (SPS_W+1)'(1)) >= {1'b0, samples_per_symbol};
    assign cls  = tbv_classify(s_timing_sample);

    assign push_item.hit  = cls.hit;
    assign push_item.bin  = cls.bin;
    assign push_item.last = last;

    always_comb begin
        position_next = position_reg;
        if (accept) begin
            position_next = last ? '0 : position_reg + SPS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
        end else begin
            position_reg <= position_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tbv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tbv_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire tbv_pkg::tbv_item_t push_item,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output tbv_pkg::tbv_item_t      pop_item
);
    import tbv_pkg::*;

    tbv_item_t           entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tbv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tbv_back #(
    parameter int COUNTER_BITS = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        pop_valid,
    output logic                             pop_ready,
    input  wire tbv_pkg::tbv_item_t          pop_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tbv_pkg::BIN_W-1:0]        m_decoded_symbol,
    output logic [tbv_pkg::BIN_W-1:0]        m_expected_symbol,
    output logic                             m_symbol_match,
    output logic [tbv_pkg::TOTAL_W-1:0]      m_correct_total
);
    import tbv_pkg::*;

    localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;

    logic [COUNTER_BITS-1:0] counts_reg  [NUM_BINS];
    logic [COUNTER_BITS-1:0] counts_next [NUM_BINS];
    logic [COUNTER_BITS-1:0] counts_upd  [NUM_BINS];

    logic [BIN_W-1:0]   symbol_counter_reg;
    logic [BIN_W-1:0]   symbol_counter_next;

    // vote stage
    logic               vote_valid_reg;
    logic               vote_valid_next;
    logic [BIN_W-1:0]   vote_decoded_reg;
    logic [BIN_W-1:0]   vote_decoded_next;
    logic [BIN_W-1:0]   vote_expected_reg;
    logic [BIN_W-1:0]   vote_expected_next;
    logic [BIN_W-1:0]   winner;
    logic [COUNTER_BITS-1:0] best;

    // result stage
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [BIN_W-1:0]   m_decoded_reg;
    logic [BIN_W-1:0]   m_decoded_next;
    logic [BIN_W-1:0]   m_expected_reg;
    logic [BIN_W-1:0]   m_expected_next;
    logic               m_match_reg;
    logic               m_match_next;
    logic [TOTAL_W-1:0] correct_count_reg;
    logic [TOTAL_W-1:0] correct_count_next;

    logic               vote_take;
    logic               vote_free;
    logic               pop;
    logic               match;

    assign vote_take = !m_valid_reg || m_ready;
    assign vote_free = !vote_valid_reg || vote_take;
    // stall only a symbol-closing item while the vote stage is full
    assign pop_ready = !pop_item.last || vote_free;
    assign pop       = pop_valid && pop_ready;
    assign match     = (vote_decoded_reg == vote_expected_reg);

    always_comb begin
        for (int b = 0; b < NUM_BINS; b++) begin
            counts_upd[b] = counts_reg[b];
            if (pop_item.hit && (pop_item.bin == BIN_W'(b)) && (counts_reg[b] != COUNT_MAX)) begin
                counts_upd[b] = counts_reg[b] + COUNTER_BITS'(1);
            end
        end
    end

    // strict greater-than keeps the lowest index on ties
    always_comb begin
        winner = '0;
        best   = counts_upd[0];
        for (int b = 1; b < NUM_BINS; b++) begin
            if (counts_upd[b] > best) begin
                winner = BIN_W'(b);
                best   = counts_upd[b];
            end
        end
    end

    always_comb begin
        counts_next         = counts_reg;
        symbol_counter_next = symbol_counter_reg;
        vote_valid_next     = vote_valid_reg && !vote_take;
        vote_decoded_next   = vote_decoded_reg;
        vote_expected_next  = vote_expected_reg;
        if (pop) begin
            if (pop_item.last) begin
                for (int b = 0; b < NUM_BINS; b++) begin
                    counts_next[b] = '0;
                end
                vote_valid_next     = 1'b1;
                vote_decoded_next   = winner;
                vote_expected_next  = symbol_counter_reg;
                symbol_counter_next = symbol_counter_reg + BIN_W'(1);
            end else begin
                counts_next = counts_upd;
            end
        end
    end

    always_comb begin
        m_valid_next       = m_valid_reg && !m_ready;
        m_decoded_next     = m_decoded_reg;
        m_expected_next    = m_expected_reg;
        m_match_next       = m_match_reg;
        correct_count_next = correct_count_reg;
        if (vote_valid_reg && vote_take) begin
            m_valid_next    = 1'b1;
            m_decoded_next  = vote_decoded_reg;
            m_expected_next = vote_expected_reg;
            m_match_next    = match;
            if (match && (correct_count_reg != '1)) begin
                correct_count_next = correct_count_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        vote_decoded_reg  <= vote_decoded_next;
        vote_expected_reg <= vote_expected_next;
        m_decoded_reg     <= m_decoded_next;
        m_expected_reg    <= m_expected_next;
        m_match_reg       <= m_match_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                counts_reg[b] <= '0;
            end
            symbol_counter_reg <= '0;
            vote_valid_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
            correct_count_reg  <= '0;
        end else begin
            counts_reg         <= counts_next;
            symbol_counter_reg <= symbol_counter_next;
            vote_valid_reg     <= vote_valid_next;
            m_valid_reg        <= m_valid_next;
            correct_count_reg  <= correct_count_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_decoded_symbol  = m_decoded_reg;
    assign m_expected_symbol = m_expected_reg;
    assign m_symbol_match    = m_match_reg;
    // the total only moves when a result loads, so it always matches the shown item
    assign m_correct_total   = correct_count_reg;

endmodule

`default_nettype wire

// File: rtl/timing_bin_vote_symbol_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Timing-bin vote symbol decoder. Each accepted item is one 16-bit timing
// sample; the front end sorts it into one of eight symbol bins by open
// ranges (a sample on a bound or outside every range counts toward no bin
// but still counts toward the symbol length) and tags the sample that
// closes a symbol. A four-entry queue hands tagged samples to the back end,
// which updates the saturating bin counters, votes at the end of each symbol
// (highest count wins, ties and an empty vote go to the lowest bin), compares
// the winner with a 3-bit symbol count and keeps a saturating 32-bit total of
// correct decodes. One result is emitted per symbol. Throughput is one sample
// per clock, sustained, as long as results are taken. A closing sample moves
// from the queue into the vote register, and its result is then loaded into
// the output register. samples_per_symbol (byte address 0, reset 6) is written
// over the APB port; the user must write it only while the block is idle, as
// the block itself does not enforce this. A value of zero behaves like one.
module timing_bin_vote_symbol_decoder #(
    parameter int COUNTER_BITS = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // sample channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tbv_pkg::SAMPLE_W-1:0] s_timing_sample,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tbv_pkg::BIN_W-1:0]         m_decoded_symbol,
    output logic [tbv_pkg::BIN_W-1:0]         m_expected_symbol,
    output logic                              m_symbol_match,
    output logic [tbv_pkg::TOTAL_W-1:0]       m_correct_total
);
    import tbv_pkg::*;

    logic [SPS_W-1:0] sps_reg;
    logic [SPS_W-1:0] sps_next;
    logic             reg_index;
    logic             cfg_write;

    logic             push_valid;
    logic             push_ready;
    tbv_item_t        push_item;
    logic             pop_valid;
    logic             pop_ready;
    tbv_item_t        pop_item;

    // register index is the word address
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        sps_next = sps_reg;
        if (cfg_write && (reg_index == REG_SAMPLES_PER_SYMBOL)) begin
            sps_next = pwdata[SPS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_SAMPLES_PER_SYMBOL) begin
            prdata = {{(32-SPS_W){1'b0}}, sps_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sps_reg <= SPS_RESET;
        end else begin
            sps_reg <= sps_next;
        end
    end

    // classify and tag symbol boundaries
    tbv_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_timing_sample    (s_timing_sample),
        .samples_per_symbol (sps_reg),
        .push_valid         (push_valid),
        .push_ready         (push_ready),
        .push_item          (push_item)
    );

    // decouple front from back so each side can stall alone
    tbv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // tally, vote and score
    tbv_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_item          (pop_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_decoded_symbol  (m_decoded_symbol),
        .m_expected_symbol (m_expected_symbol),
        .m_symbol_match    (m_symbol_match),
        .m_correct_total   (m_correct_total)
    );

    // match flag must agree with the two symbols it reports
    a_match_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_symbol_match == (m_decoded_symbol == m_expected_symbol)))
        else $error("symbol_match disagrees with decoded and expected symbols");

    // a correct decode leaves a nonzero total
    a_total_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_symbol_match) |-> (m_correct_total != '0))
        else $error("correct total is zero on a matching result");

    // drop any pending result on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// File: dv/tbv_checker.sv
`timescale 1ns / 1ps

module tbv_checker #(
    parameter int COUNTER_BITS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [tbv_pkg::SAMPLE_W-1:0] s_timing_sample,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [tbv_pkg::BIN_W-1:0]    m_decoded_symbol,
    input  logic [tbv_pkg::BIN_W-1:0]    m_expected_symbol,
    input  logic                         m_symbol_match,
    input  logic [tbv_pkg::TOTAL_W-1:0]  m_correct_total,
    output int unsigned                  fault_total,
    output int unsigned                  awaiting
);
    import tbv_pkg::*;

    typedef struct packed {
        logic [BIN_W-1:0]   decoded;
        logic [BIN_W-1:0]   sent;
        logic               match;
        logic [TOTAL_W-1:0] total;
    } symbol_t;

    localparam logic [2:0]              LEN_ADDR  = {REG_SAMPLES_PER_SYMBOL, 2'b00};
    localparam logic [COUNTER_BITS-1:0] TALLY_MAX = '1;

    logic [SPS_W-1:0]        sym_len;
    logic [SPS_W-1:0]        position;
    logic [BIN_W-1:0]        sym_idx;
    logic [TOTAL_W-1:0]      correct;
    logic [COUNTER_BITS-1:0] tally [NUM_BINS];
    symbol_t                 due_symbols [$];
    int unsigned             faults = 0;

    // open ranges, first hit wins
    function automatic int bin_of(input logic [SAMPLE_W-1:0] v);
        if (v > 16'd3100 && v < 16'd3400) return 0;
        if (v > 16'd3400 && v < 16'd3600) return 1;
        if (v > 16'd3600 && v < 16'd3800) return 2;
        if (v > 16'd3800 && v < 16'd3880) return 3;
        if (v > 16'd2600 && v < 16'd3100) return 4;
        if (v > 16'd3880 && v < 16'd4100) return 5;
        if (v > 16'd4650 && v < 16'd6000) return 6;
        if (v > 16'd4100 && v < 16'd4650) return 7;
        return -1;
    endfunction

    task automatic note_fault(input string what);
        faults++;
        if (faults <= 10) $display("%t %s", $realtime, what);
    endtask

    // count one sample and close the symbol when its length is reached
    task automatic take_sample(input logic [SAMPLE_W-1:0] v);
        int      hit;
        int      best;
        symbol_t s;
        hit = bin_of(v);
        if (hit >= 0 && tally[hit] != TALLY_MAX) tally[hit] = tally[hit] + 1'b1;
        if (int'(position) + 1 < int'(sym_len)) begin
            position = position + 1'b1;
        end else begin
            best = 0;
            for (int b = 1; b < NUM_BINS; b++) begin
                if (tally[b] > tally[best]) best = b;
            end
            s.decoded = BIN_W'(best);
            s.sent    = sym_idx;
            s.match   = (s.decoded == sym_idx);
            if (s.match && correct != '1) correct = correct + 1'b1;
            s.total = correct;
            due_symbols.push_back(s);
            for (int b = 0; b < NUM_BINS; b++) tally[b] = '0;
            position = '0;
            sym_idx  = sym_idx + 1'b1;
        end
    endtask

    always @(posedge aclk) begin : watch
        symbol_t want;
        if (!aresetn) begin
            sym_len  = SPS_RESET;
            position = '0;
            sym_idx  = '0;
            correct  = '0;
            for (int b = 0; b < NUM_BINS; b++) tally[b] = '0;
            due_symbols.delete();
        end else begin
            if (psel && penable && pready && paddr == LEN_ADDR) begin
                if (pwrite) begin
                    sym_len = pwdata[SPS_W-1:0];
                end else if (prdata !== 32'(sym_len)) begin
                    note_fault($sformatf("register read: got %0d want %0d",
                                         prdata, sym_len));
                end
            end
            if (m_valid && m_ready) begin
                if (due_symbols.size() == 0) begin
                    note_fault($sformatf("result with no symbol due: dec %0d exp %0d",
                                         m_decoded_symbol, m_expected_symbol));
                end else begin
                    want = due_symbols.pop_front();
                    if (m_decoded_symbol !== want.decoded || m_expected_symbol !== want.sent ||
                        m_symbol_match !== want.match || m_correct_total !== want.total) begin
                        note_fault($sformatf(
                            "mismatch: got %0d %0d %0b %0d want %0d %0d %0b %0d",
                            m_decoded_symbol, m_expected_symbol, m_symbol_match,
                            m_correct_total, want.decoded, want.sent, want.match,
                            want.total));
                    end
                end
            end
            if (s_valid && s_ready) take_sample(s_timing_sample);
        end
        fault_total <= faults;
        awaiting    <= due_symbols.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tbv_pkg::*;

    localparam int         COUNTER_BITS = 4;
    localparam logic [2:0] LEN_ADDR     = {REG_SAMPLES_PER_SYMBOL, 2'b00};

    // bounds, values outside every range and one value inside each bin
    localparam logic [SAMPLE_W-1:0] CORNER_TIMES [20] = '{
        16'd0,    16'd65535, 16'd3100, 16'd3400, 16'd3600,
        16'd3800, 16'd3880,  16'd2600, 16'd4100, 16'd4650,
        16'd6000, 16'd3250,  16'd3500, 16'd3700, 16'd3840,
        16'd2850, 16'd3990,  16'd5000, 16'd4300, 16'd5999
    };
    // pairs for a two-sample symbol: two ties, then a clear winner
    localparam logic [SAMPLE_W-1:0] TIE_TIMES [6] = '{
        16'd3250, 16'd3500, 16'd3500, 16'd3250, 16'd3990, 16'd3990
    };
    // symbol lengths per random phase; the last few are drawn at random
    localparam logic [SPS_W-1:0] LEN_PLAN [12] = '{
        4'd15, 4'd0, 4'd6, 4'd1, 4'd2, 4'd15, 4'd3, 4'd9, 4'd1, 4'd4, 4'd7, 4'd5
    };

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [2:0]            paddr           = '0;
    logic [31:0]           pwdata          = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_timing_sample = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [BIN_W-1:0]      m_decoded_symbol;
    logic [BIN_W-1:0]      m_expected_symbol;
    logic                  m_symbol_match;
    logic [TOTAL_W-1:0]    m_correct_total;
    int unsigned           fault_total;
    int unsigned           awaiting;

    logic [SPS_W-1:0]      cur_len         = SPS_RESET;
    bit                    calm            = 1'b0;
    int unsigned           stall_left      = 0;
    int unsigned           run_left        = 0;

    always #4 aclk = ~aclk;

    timing_bin_vote_symbol_decoder #(
        .COUNTER_BITS(COUNTER_BITS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_timing_sample  (s_timing_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_decoded_symbol (m_decoded_symbol),
        .m_expected_symbol(m_expected_symbol),
        .m_symbol_match   (m_symbol_match),
        .m_correct_total  (m_correct_total)
    );

    tbv_checker #(
        .COUNTER_BITS(COUNTER_BITS)
    ) symbol_watch (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_timing_sample  (s_timing_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_decoded_symbol (m_decoded_symbol),
        .m_expected_symbol(m_expected_symbol),
        .m_symbol_match   (m_symbol_match),
        .m_correct_total  (m_correct_total),
        .fault_total      (fault_total),
        .awaiting         (awaiting)
    );

    // Result side: alternate free-running stretches with short and long stalls,
    // so back-pressure lands on every stage of the pipeline.
    always @(posedge aclk) begin : sink
        int unsigned roll;
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (run_left != 0) begin
            m_ready <= 1'b1;
            run_left--;
        end else begin
            roll = $urandom_range(99, 0);
            if (roll < 60) begin
                m_ready  <= 1'b1;
                run_left = $urandom_range(60, 1);
            end else if (roll < 92) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(3, 0);
            end else begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(40, 8);
            end
        end
    end

    // Sender gap: none while calm, otherwise mostly short and now and then long.
    function automatic int unsigned gap_draw();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Pick one timing value: mostly inside the aimed bin, the rest spread over
    // other bins, exact bounds, raw noise and the two extremes.
    function automatic logic [SAMPLE_W-1:0] timing_draw(input int unsigned aim);
        int unsigned roll;
        int unsigned b;
        roll = $urandom_range(99, 0);
        b    = $urandom_range(NUM_BINS - 1, 0);
        if (roll < 70) return SAMPLE_W'($urandom_range(BIN_HIGH[aim] - 1, BIN_LOW[aim] + 1));
        if (roll < 80) return SAMPLE_W'($urandom_range(BIN_HIGH[b] - 1, BIN_LOW[b] + 1));
        if (roll < 88) return roll[0] ? BIN_HIGH[b] : BIN_LOW[b];
        if (roll < 95) return SAMPLE_W'($urandom());
        return roll[0] ? '1 : '0;
    endfunction

    // Offer one item after an optional gap and hold it until it is taken.
    // s_valid gets exactly one assignment per time step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_timing_sample <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait until every predicted symbol has come out, then let the
    // pipeline empty of samples that close no symbol.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (8) @(posedge aclk);
    endtask

    // One APB transfer to the symbol length register: setup, access, release.
    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LEN_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a new symbol length with junk in the unused upper bits, read it back.
    task automatic set_len(input logic [SPS_W-1:0] len);
        apb_access(1'b1, {28'($urandom()), len});
        apb_access(1'b0, '0);
        cur_len = len;
    endtask

    initial begin : stimulus
        int unsigned aim;
        int unsigned count;
        aim   = 0;
        count = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // check the reset length before anything is written
        apb_access(1'b0, '0);

        // one sample per symbol: bounds, extremes and each bin on its own
        set_len(4'd1);
        foreach (CORNER_TIMES[i]) send_sample(CORNER_TIMES[i], gap_draw());
        drain();

        // two samples per symbol: ties go to the lower bin
        set_len(4'd2);
        foreach (TIE_TIMES[i]) send_sample(TIE_TIMES[i], gap_draw());
        drain();

        // Random phases. Phase lengths need not be multiples of the symbol length,
        // so a symbol is often left open when the length is lowered.
        for (int p = 0; p < 12; p++) begin
            set_len(p < 9 ? LEN_PLAN[p] : SPS_W'($urandom_range(15, 0)));
            count = $urandom_range(170, 120);
            for (int n = 0; n < count; n++) begin
                if (n % 40 == 0) calm = ($urandom_range(9, 0) < 3);
                // re-aim roughly once per symbol
                if (n % ((cur_len == 0) ? 1 : cur_len) == 0) aim = $urandom_range(NUM_BINS - 1, 0);
                send_sample(timing_draw(aim), gap_draw());
                // now and then hold off until the result side is empty
                if ($urandom_range(199, 0) == 0) drain();
            end
            drain();
        end

        if (fault_total == 0 && awaiting == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // stop a hung run
    initial begin : watchdog
        #6_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
